[rtl/core/nnfs_pkg.sv]
`timescale 1ns / 1ps

package nnfs_pkg;

    // Coordinate and size widths
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS + 1;
    localparam int SPAN_BITS  = 3;
    localparam int CHAN_BITS  = 8;

    localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = SIZE_BITS'(1) << COORD_BITS;

    // Configuration register indexes
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_COLOR_MODE = 3'd4;

    // Effective image sizes seen by the datapath
    typedef struct packed {
        logic [SIZE_BITS-1:0] src_w;
        logic [SIZE_BITS-1:0] src_h;
        logic [SIZE_BITS-1:0] dst_w;
        logic [SIZE_BITS-1:0] dst_h;
        logic                 color;
    } scale_cfg_t;

    // One pixel's write span, handed from the front part to the back part
    typedef struct packed {
        logic [COORD_BITS-1:0] col_start;
        logic [COORD_BITS-1:0] row_start;
        logic [SPAN_BITS-1:0]  col_last;
        logic [SPAN_BITS-1:0]  row_last;
        logic [CHAN_BITS-1:0]  chan_c;
        logic [CHAN_BITS-1:0]  chan_b;
        logic [CHAN_BITS-1:0]  chan_a;
    } span_entry_t;

    // Zero acts as one, anything past the coordinate range acts as the limit
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] r;
        if (v == '0)
            r = SIZE_BITS'(1);
        else if (v > SIZE_LIMIT)
            r = SIZE_LIMIT;
        else
            r = v;
        return r;
    endfunction

endpackage

[rtl/core/nnfs_div.sv]
`timescale 1ns / 1ps

module nnfs_div
    import nnfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_BITS-1:0] dividend,
    input  logic [SIZE_BITS-1:0] divisor,
    output logic [SIZE_BITS-1:0] quotient,
    output logic                 done
);

    localparam int QUOT_BITS = SIZE_BITS;
    localparam int DIV_STEPS = 4;
    localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic [QUOT_BITS-1:0] quo_reg, quo_next;

    // Restoring division, four quotient bits per cycle; the upper dividend
    // bits start out below the divisor because the quotient fits QUOT_BITS
    always_comb
    begin
        logic [SIZE_BITS:0]   trial;
        logic [SIZE_BITS-1:0] rem_v;
        logic [QUOT_BITS-1:0] quo_v;
        trial = '0;
        rem_v = rem_reg;
        quo_v = quo_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (CNT_BITS'(k) < cnt_reg)
            begin
                trial = {rem_v, quo_v[QUOT_BITS-1]};
                quo_v = {quo_v[QUOT_BITS-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    rem_v    = SIZE_BITS'(trial - {1'b0, divisor});
                    quo_v[0] = 1'b1;
                end
                else
                begin
                    rem_v = trial[SIZE_BITS-1:0];
                end
            end
        end
        if (start)
        begin
            rem_next = SIZE_BITS'(dividend[PROD_BITS-1:QUOT_BITS]);
            quo_next = dividend[QUOT_BITS-1:0];
            cnt_next = CNT_BITS'(QUOT_BITS);
        end
        else
        begin
            rem_next = rem_v;
            quo_next = quo_v;
            cnt_next = (cnt_reg > CNT_BITS'(DIV_STEPS)) ? cnt_reg - CNT_BITS'(DIV_STEPS) : '0;
        end
    end

    // Hold the step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

[rtl/core/nnfs_front.sv]
`timescale 1ns / 1ps

module nnfs_front
    import nnfs_pkg::*;
#(
    parameter int MAX_SPAN     = 8,
    parameter int NUM_CHANNELS = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scale_cfg_t             cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAN_BITS-1:0]   in_a,
    input  logic [CHAN_BITS-1:0]   in_b,
    input  logic [CHAN_BITS-1:0]   in_c,
    input  logic                   q_full,
    output logic                   q_push,
    output span_entry_t            q_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

    state_t                state_reg;
    logic [COORD_BITS-1:0] col_pos_reg, row_pos_reg;
    logic                  col_end_reg, row_end_reg;
    logic [COORD_BITS-1:0] col_x_reg, row_x_reg;
    logic [CHAN_BITS-1:0]  a_reg, b_reg, c_reg;

    logic                  accept;
    logic                  col_end, row_end;
    logic [SIZE_BITS-1:0]  sw_m1, sh_m1;
    logic                  div_start;
    logic [PROD_BITS-1:0]  col_lo_prod, col_hi_prod, row_lo_prod, row_hi_prod;
    logic [SIZE_BITS-1:0]  col_lo_q, col_hi_q, row_lo_q, row_hi_q;
    logic                  col_lo_done, col_hi_done, row_lo_done, row_hi_done;
    logic                  div_done;
    logic [SIZE_BITS-1:0]  col_diff, row_diff;
    logic [SPAN_BITS-1:0]  col_cnt, row_cnt;

    localparam logic [SIZE_BITS-1:0] SPAN_CAP = SIZE_BITS'(MAX_SPAN - 1);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Classify the incoming pixel against the image edges
    assign sw_m1   = cfg.src_w - SIZE_BITS'(1);
    assign sh_m1   = cfg.src_h - SIZE_BITS'(1);
    assign col_end = ({1'b0, col_pos_reg} >= sw_m1);
    assign row_end = ({1'b0, row_pos_reg} >= sh_m1);

    // Scale the positions by the destination size
    assign div_start   = (state_reg == ST_MUL);
    assign col_lo_prod = PROD_BITS'(col_x_reg * cfg.dst_w);
    assign col_hi_prod = PROD_BITS'((SIZE_BITS'(col_x_reg) + SIZE_BITS'(1)) * cfg.dst_w);
    assign row_lo_prod = PROD_BITS'(row_x_reg * cfg.dst_h);
    assign row_hi_prod = PROD_BITS'((SIZE_BITS'(row_x_reg) + SIZE_BITS'(1)) * cfg.dst_h);

    nnfs_div u_div_col_lo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (col_lo_prod),
        .divisor  (cfg.src_w),
        .quotient (col_lo_q),
        .done     (col_lo_done)
    );

    nnfs_div u_div_col_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (col_hi_prod),
        .divisor  (cfg.src_w),
        .quotient (col_hi_q),
        .done     (col_hi_done)
    );

    nnfs_div u_div_row_lo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (row_lo_prod),
        .divisor  (cfg.src_h),
        .quotient (row_lo_q),
        .done     (row_lo_done)
    );

    nnfs_div u_div_row_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (row_hi_prod),
        .divisor  (cfg.src_h),
        .quotient (row_hi_q),
        .done     (row_hi_done)
    );

    assign div_done = col_lo_done && col_hi_done && row_lo_done && row_hi_done;

    // Cap the spans; an edge pixel writes one line along that axis
    assign col_diff = col_hi_q - col_lo_q;
    assign row_diff = row_hi_q - row_lo_q;
    assign col_cnt  = col_end_reg ? '0 :
                      (col_diff > SPAN_CAP) ? SPAN_BITS'(SPAN_CAP) : col_diff[SPAN_BITS-1:0];
    assign row_cnt  = row_end_reg ? '0 :
                      (row_diff > SPAN_CAP) ? SPAN_BITS'(SPAN_CAP) : row_diff[SPAN_BITS-1:0];

    assign q_push = (state_reg == ST_DIV) && div_done && !q_full;

    always_comb
    begin
        q_data.col_start = col_lo_q[COORD_BITS-1:0];
        q_data.row_start = row_lo_q[COORD_BITS-1:0];
        q_data.col_last  = col_cnt;
        q_data.row_last  = row_cnt;
        q_data.chan_a    = a_reg;
        q_data.chan_b    = b_reg;
        q_data.chan_c    = c_reg;
    end

    // Sequence one pixel and track the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            col_end_reg <= 1'b0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        col_end_reg <= col_end;
                        row_end_reg <= row_end;
                        if (col_end)
                        begin
                            col_pos_reg <= '0;
                            row_pos_reg <= row_end ? '0 : row_pos_reg + COORD_BITS'(1);
                        end
                        else
                        begin
                            col_pos_reg <= col_pos_reg + COORD_BITS'(1);
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (q_push)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the pixel value and its clamped position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_x_reg <= col_end ? sw_m1[COORD_BITS-1:0] : col_pos_reg;
            row_x_reg <= row_end ? sh_m1[COORD_BITS-1:0] : row_pos_reg;
            a_reg     <= in_a;
            b_reg     <= (NUM_CHANNELS > 1 && cfg.color) ? in_b : '0;
            c_reg     <= (NUM_CHANNELS > 2 && cfg.color) ? in_c : '0;
        end
    end

endmodule

[rtl/core/nnfs_fifo.sv]
`timescale 1ns / 1ps

module nnfs_fifo
    import nnfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  span_entry_t wr_data,
    input  logic        pop,
    output span_entry_t rd_data,
    output logic        full,
    output logic        empty
);

    localparam int DEPTH    = 2;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    span_entry_t         slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_BITS'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_BITS'(1);
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[rtl/core/nnfs_back.sv]
`timescale 1ns / 1ps

module nnfs_back
    import nnfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  span_entry_t            q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  out_col,
    output logic [COORD_BITS-1:0]  out_row,
    output logic [CHAN_BITS-1:0]   out_a,
    output logic [CHAN_BITS-1:0]   out_b,
    output logic [CHAN_BITS-1:0]   out_c,
    output logic                   out_last
);

    logic                  busy_reg;
    span_entry_t           ent_reg;
    logic [SPAN_BITS-1:0]  col_i_reg, row_j_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_col_reg, out_row_reg;
    logic [CHAN_BITS-1:0]  out_a_reg, out_b_reg, out_c_reg;
    logic                  out_last_reg;

    logic                  load_out;
    logic                  emit;
    logic                  row_done;
    logic                  final_write;

    assign load_out    = !out_valid_reg || out_ready;
    assign emit        = busy_reg && load_out;
    assign row_done    = (row_j_reg == ent_reg.row_last);
    assign final_write = row_done && (col_i_reg == ent_reg.col_last);
    assign q_pop       = !q_empty && (!busy_reg || (emit && final_write));

    // Walk the span column by column, rows fastest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            col_i_reg     <= '0;
            row_j_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg  <= 1'b1;
                col_i_reg <= '0;
                row_j_reg <= '0;
            end
            else if (emit)
            begin
                if (final_write)
                begin
                    busy_reg <= 1'b0;
                end
                else if (row_done)
                begin
                    row_j_reg <= '0;
                    col_i_reg <= col_i_reg + SPAN_BITS'(1);
                end
                else
                begin
                    row_j_reg <= row_j_reg + SPAN_BITS'(1);
                end
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the span entry and the output beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
            ent_reg <= q_data;
        if (emit)
        begin
            out_col_reg  <= ent_reg.col_start + COORD_BITS'(col_i_reg);
            out_row_reg  <= ent_reg.row_start + COORD_BITS'(row_j_reg);
            out_a_reg    <= ent_reg.chan_a;
            out_b_reg    <= ent_reg.chan_b;
            out_c_reg    <= ent_reg.chan_c;
            out_last_reg <= final_write;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_c     = out_c_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/nearest_neighbour_forward_scaler.sv]
`timescale 1ns / 1ps

// Nearest-neighbor forward scaler. Source pixels enter in raster order on the
// slave stream; for each one the block sends destination write beats
// (column, row, channel bytes) covering the pixel's block of destination
// columns and rows, at most MAX_SPAN along each axis, column by column with
// rows fastest, tlast on the last beat of the pixel. The front part takes one
// pixel at a time: it accepts the pixel, forms the size products, then waits
// for the shared-shape four-bit-per-cycle dividers that form the span bounds
// and for room in the span queue. The back part sends one write beat per
// cycle while the sink is ready, from the two-entry span queue.
// Set the size and color registers only while the block is idle.

module nearest_neighbour_forward_scaler
    import nnfs_pkg::*;
#(
    parameter int MAX_SPAN     = 8,
    parameter int NUM_CHANNELS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [SIZE_BITS-1:0]  cfg_data,
    // Source pixels
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // chan_a, chan_b, chan_c
    // Destination writes
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // dest_col, dest_row, out_a, out_b, out_c
    output logic                  m_axis_tlast    // last_write
);

    logic [SIZE_BITS-1:0] src_width_reg, src_height_reg;
    logic [SIZE_BITS-1:0] dst_width_reg, dst_height_reg;
    logic                 color_mode_reg;
    scale_cfg_t           cfg;

    span_entry_t           push_data, pop_data;
    logic                  q_push, q_pop, q_full, q_empty;
    logic [COORD_BITS-1:0] dest_col, dest_row;
    logic [CHAN_BITS-1:0]  out_a, out_b, out_c;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SIZE_BITS'(1);
            src_height_reg <= SIZE_BITS'(1);
            dst_width_reg  <= SIZE_BITS'(1);
            dst_height_reg <= SIZE_BITS'(1);
            color_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                REG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp sizes into the usable range
    always_comb
    begin
        cfg.src_w = eff_size(src_width_reg);
        cfg.src_h = eff_size(src_height_reg);
        cfg.dst_w = eff_size(dst_width_reg);
        cfg.dst_h = eff_size(dst_height_reg);
        cfg.color = color_mode_reg;
    end

    nnfs_front #(
        .MAX_SPAN     (MAX_SPAN),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_a     (s_axis_tdata[7:0]),
        .in_b     (s_axis_tdata[15:8]),
        .in_c     (s_axis_tdata[23:16]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    nnfs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .pop     (q_pop),
        .rd_data (pop_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    nnfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_col   (dest_col),
        .out_row   (dest_row),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_c, out_b, out_a, dest_row, dest_col};

    // The queue is never written when full nor read when empty
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("span queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("span queue read while empty");

    // The front part works on one pixel at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("front part took a second pixel while busy");

endmodule
